FILE: rtl/core/occupancy_frontier_mask_assert.svh
// ----------------------------------------------------------------------------
// occupancy_frontier_mask_assert.svh
// Assertion macros for the frontier mask block. Clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_FRONTIER_MASK_ASSERT_SVH
`define OCCUPANCY_FRONTIER_MASK_ASSERT_SVH

// same-cycle implication
`define OFM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("occupancy_frontier_mask: same-cycle check failed");

// next-cycle implication
`define OFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("occupancy_frontier_mask: next-cycle check failed");

`endif

FILE: rtl/core/ofm_pkg.sv
// ----------------------------------------------------------------------------
// ofm_pkg
// Shared types and constants of the occupancy frontier mask.
// ----------------------------------------------------------------------------
package ofm_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_RESET   = 1024;
    localparam int HEIGHT_RESET  = 1024;
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_W      = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int CELL_W        = 8;
    localparam int CLASS_W       = 2;

    typedef enum logic [CLASS_W-1:0] {
        CLS_FREE     = 2'd0,
        CLS_UNKNOWN  = 2'd1,
        CLS_OCCUPIED = 2'd2
    } t_class;

    typedef enum logic {
        OP_CELL  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } t_cfg_idx;

    // per-item control word from the position tracker
    typedef struct packed {
        logic   keep;       // item moves the window
        logic   produce;    // item releases a result
        logic   at_left;
        logic   at_right;
        logic   at_top;
        logic   at_bottom;
        logic   last;       // result is the final cell of the map
        t_class cls;        // class entering the window
    } t_step;

endpackage

FILE: rtl/core/ofm_ifs.sv
// ----------------------------------------------------------------------------
// ofm_ifs
// Valid/ready channels of the frontier mask: cells in, results out, config.
// ----------------------------------------------------------------------------
interface ofm_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [ofm_pkg::CELL_W-1:0]   cell_value;

    modport source (output valid, op, cell_value, input ready);
    modport sink   (input valid, op, cell_value, output ready);
endinterface

interface ofm_out_if;
    logic                                valid;
    logic                                ready;
    logic                                is_frontier;
    logic [ofm_pkg::CLASS_W-1:0]         cell_class;
    logic                                last_in_frame;

    modport source (output valid, is_frontier, cell_class, last_in_frame, input ready);
    modport sink   (input valid, is_frontier, cell_class, last_in_frame, output ready);
endinterface

interface ofm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ofm_pkg::CFG_IDX_W-1:0]       index;
    logic [ofm_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ofm_ram.sv
// ----------------------------------------------------------------------------
// ofm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ofm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ofm_ctrl.sv
// ----------------------------------------------------------------------------
// ofm_ctrl
// Map geometry registers and input/output raster position tracking.
// ----------------------------------------------------------------------------
module ofm_ctrl #(
    parameter int MAX_WIDTH = ofm_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ofm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ofm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_accept,
    input  logic                               i_op,
    input  logic signed [ofm_pkg::CELL_W-1:0]  i_cell_value,
    output ofm_pkg::t_step                     o_step,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_col
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > ofm_pkg::WIDTH_REG_W) ? WW : ofm_pkg::WIDTH_REG_W;
    localparam int HW = ofm_pkg::HEIGHT_W;
    localparam int RW = HW + 1;     // input row runs past the map while draining
    localparam int WIDTH_INIT =
        (ofm_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : ofm_pkg::WIDTH_RESET;

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [AW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [AW-1:0] r_out_col;
    logic [HW-1:0] r_out_row;

    logic [AW-1:0] n_in_col;
    logic [RW-1:0] n_in_row;

    logic [CW-1:0] cfg_width_raw;
    logic [WW-1:0] cfg_width;
    logic [HW-1:0] cfg_height;
    logic [WW-1:0] width_m1;
    logic [AW-1:0] col_last;
    logic [HW-1:0] row_last;
    logic          past;
    logic          is_drain;
    logic          col_wrap;
    logic          primed;
    ofm_pkg::t_step step;

    // clamp the written geometry once, at write time
    always_comb begin
        cfg_width_raw = CW'(i_cfg_data[ofm_pkg::WIDTH_REG_W-1:0]);
        if (cfg_width_raw == '0) begin
            cfg_width = WW'(1);
        end else if (cfg_width_raw > CW'(MAX_WIDTH)) begin
            cfg_width = WW'(MAX_WIDTH);
        end else begin
            cfg_width = cfg_width_raw[WW-1:0];
        end
        cfg_height = (i_cfg_data[HW-1:0] == '0) ? HW'(1) : i_cfg_data[HW-1:0];
    end

    assign width_m1 = r_width - WW'(1);
    assign col_last = width_m1[AW-1:0];
    assign row_last = r_height - HW'(1);

    always_comb begin
        past     = r_in_row >= {1'b0, r_height};
        is_drain = ofm_pkg::t_op'(i_op) == ofm_pkg::OP_DRAIN;
        col_wrap = r_in_col == col_last;
        n_in_col = col_wrap ? '0 : r_in_col + AW'(1);
        n_in_row = col_wrap ? r_in_row + RW'(1) : r_in_row;
        // one row and one cell consumed: results flow from here on
        primed   = (n_in_row >= RW'(2)) || ((n_in_row == RW'(1)) && (n_in_col != '0));

        step.keep      = !(is_drain && !past);
        step.produce   = step.keep && primed;
        step.at_left   = r_out_col == '0;
        step.at_right  = r_out_col == col_last;
        step.at_top    = r_out_row == '0;
        step.at_bottom = r_out_row == row_last;
        step.last      = step.produce && step.at_right && step.at_bottom;
        if (past || is_drain) begin
            step.cls = ofm_pkg::CLS_FREE;
        end else if (i_cell_value == '0) begin
            step.cls = ofm_pkg::CLS_FREE;
        end else if (i_cell_value[ofm_pkg::CELL_W-1]) begin
            step.cls = ofm_pkg::CLS_UNKNOWN;
        end else begin
            step.cls = ofm_pkg::CLS_OCCUPIED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WW'(WIDTH_INIT);
            r_height  <= HW'(ofm_pkg::HEIGHT_RESET);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_we) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            case (ofm_pkg::t_cfg_idx'(i_cfg_idx))
                ofm_pkg::REG_MAP_WIDTH: begin
                    r_width <= cfg_width;
                end
                ofm_pkg::REG_MAP_HEIGHT: begin
                    r_height <= cfg_height;
                end
                default: begin
                end
            endcase
        end else if (i_accept && step.keep) begin
            if (step.last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
                if (step.produce) begin
                    if (step.at_right) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + HW'(1);
                    end else begin
                        r_out_col <= r_out_col + AW'(1);
                    end
                end
            end
        end
    end

    assign o_step = step;
    assign o_col  = r_in_col;

endmodule

FILE: rtl/core/ofm_window.sv
// ----------------------------------------------------------------------------
// ofm_window
// 3x3 class window and the masked frontier test on its center.
// ----------------------------------------------------------------------------
module ofm_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_fire,
    input  ofm_pkg::t_step      i_step,
    input  ofm_pkg::t_class     i_top,
    input  ofm_pkg::t_class     i_mid,
    output logic                o_frontier,
    output ofm_pkg::t_class     o_center
);

    // index 0 top row, 2 bottom row; r_col_a older than r_col_b
    ofm_pkg::t_class [2:0] r_col_a;
    ofm_pkg::t_class [2:0] r_col_b;
    ofm_pkg::t_class [2:0] col_new;

    logic hit_left;
    logic hit_mid;
    logic hit_right;

    function automatic logic unk(input ofm_pkg::t_class c);
        return c == ofm_pkg::CLS_UNKNOWN;
    endfunction

    always_comb begin
        col_new[0] = i_top;
        col_new[1] = i_mid;
        col_new[2] = i_step.cls;

        hit_left  = !i_step.at_left &&
                    ((!i_step.at_top && unk(r_col_a[0])) || unk(r_col_a[1]) ||
                     (!i_step.at_bottom && unk(r_col_a[2])));
        hit_mid   = (!i_step.at_top && unk(r_col_b[0])) ||
                    (!i_step.at_bottom && unk(r_col_b[2]));
        hit_right = !i_step.at_right &&
                    ((!i_step.at_top && unk(col_new[0])) || unk(col_new[1]) ||
                     (!i_step.at_bottom && unk(col_new[2])));

        o_center   = r_col_b[1];
        o_frontier = (r_col_b[1] == ofm_pkg::CLS_FREE) && (hit_left || hit_mid || hit_right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col_a <= '{default: ofm_pkg::CLS_FREE};
            r_col_b <= '{default: ofm_pkg::CLS_FREE};
        end else if (i_fire) begin
            if (i_step.last) begin
                r_col_a <= '{default: ofm_pkg::CLS_FREE};
                r_col_b <= '{default: ofm_pkg::CLS_FREE};
            end else begin
                r_col_a <= r_col_b;
                r_col_b <= col_new;
            end
        end
    end

endmodule

FILE: rtl/core/occupancy_frontier_mask.sv
// ----------------------------------------------------------------------------
// occupancy_frontier_mask
// Streaming 3x3 frontier detector for an occupancy grid. Cells enter in raster
// order on i_cell, at most one per clock; each is classed free, unknown or occupied
// and pushed through a two-row line store (one MAX_WIDTH x 4-bit RAM with a
// registered read) and a 3x3 class window. The result for a cell leaves on
// o_result map_width + 1 items after that cell, so the last map_width + 1
// results need drain items (or extra cells) once the map is complete; a drain
// sent earlier is dropped and gives nothing. Pipeline: item register with the
// line store read, then the result register; the result register is loaded
// when the item that releases it leaves the item register, and the block
// takes one item every clock as long as the result side keeps up. When the
// same column is read and written in one cycle (a one-cell-wide map) the write
// data is bypassed. The line store needs no clearing after reset. A register
// write restarts the map; the write port is ready only while the item and
// result registers are empty, and a cell offered in that cycle waits.
// ----------------------------------------------------------------------------
`include "occupancy_frontier_mask_assert.svh"

module occupancy_frontier_mask #(
    parameter int MAX_WIDTH = ofm_pkg::MAX_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ofm_cfg_if.sink        i_cfg,
    ofm_in_if.sink         i_cell,
    ofm_out_if.source      o_result
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CLW = ofm_pkg::CLASS_W;

    // handshakes
    logic           cfg_we;
    logic           in_ready;
    logic           accept;
    logic           s1_fire;

    // position tracker output, valid at accept
    ofm_pkg::t_step step;
    logic [AW-1:0]  step_col;

    // item stage
    logic           r_s1_valid;
    ofm_pkg::t_step r_s1_step;
    logic [AW-1:0]  r_s1_col;
    logic           r_fwd;          // store read bypassed by the write of the same cycle
    logic [2*CLW-1:0] r_fwd_data;

    // line store: {upper row, middle row} class per column
    logic [2*CLW-1:0] ram_rdata;
    logic [2*CLW-1:0] store_rd;
    logic [2*CLW-1:0] store_wr;
    ofm_pkg::t_class  top_cls;
    ofm_pkg::t_class  mid_cls;

    // window result
    logic             frontier;
    ofm_pkg::t_class  center;

    // result register
    logic             r_o_valid;
    logic             r_o_frontier;
    ofm_pkg::t_class  r_o_class;
    logic             r_o_last;

    // register writes only land on an idle block
    assign i_cfg.ready = !r_s1_valid && !r_o_valid;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    // item stage drains whenever the result register is free or being taken
    assign s1_fire      = r_s1_valid && (!r_o_valid || o_result.ready);
    assign in_ready     = (!r_s1_valid || s1_fire) && !cfg_we;
    assign i_cell.ready = in_ready;
    assign accept       = i_cell.valid && in_ready;

    ofm_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_accept     (accept),
        .i_op         (i_cell.op),
        .i_cell_value (i_cell.cell_value),
        .o_step       (step),
        .o_col        (step_col)
    );

    // column shifts down a row: old middle becomes upper, new class becomes middle
    assign store_rd = r_fwd ? r_fwd_data : ram_rdata;
    assign top_cls  = ofm_pkg::t_class'(store_rd[2*CLW-1:CLW]);
    assign mid_cls  = ofm_pkg::t_class'(store_rd[CLW-1:0]);
    assign store_wr = {mid_cls, r_s1_step.cls};

    ofm_ram #(
        .WIDTH (2 * CLW),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (store_wr),
        .i_re    (accept && step.keep),
        .i_raddr (step_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= step.keep;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step.keep) begin
            r_s1_step  <= step;
            r_s1_col   <= step_col;
            r_fwd      <= s1_fire && (r_s1_col == step_col);
            r_fwd_data <= store_wr;
        end
    end

    ofm_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_we),
        .i_fire     (s1_fire),
        .i_step     (r_s1_step),
        .i_top      (top_cls),
        .i_mid      (mid_cls),
        .o_frontier (frontier),
        .o_center   (center)
    );

    // result register: loaded only by items that release a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_fire) begin
            r_o_valid <= r_s1_step.produce;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_step.produce) begin
            r_o_frontier <= frontier;
            r_o_class    <= center;
            r_o_last     <= r_s1_step.last;
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.is_frontier   = r_o_frontier;
    assign o_result.cell_class    = r_o_class;
    assign o_result.last_in_frame = r_o_last;

    // a frontier is always a free cell
    `OFM_ASSERT_NOW(a_frontier_free, r_o_valid && r_o_frontier, r_o_class == ofm_pkg::CLS_FREE)
    // an item that releases a result shows it in the next cycle
    `OFM_ASSERT_NEXT(a_result_follows, s1_fire && r_s1_step.produce, r_o_valid)
    // an early drain leaves the item stage empty
    `OFM_ASSERT_NEXT(a_drain_dropped, accept && !step.keep, !r_s1_valid)

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the occupancy frontier mask. A class-based tracker
// runs its own line stores and 3x3 class window on every word it does not drop and
// queues the result each word releases. Results are compared field by field
// in order. Directed maps cover value extremes, early drains, cells past the
// end and zero registers, plus one very tall partial map. Random maps of
// small sizes follow. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAP_ITEMS   = 780;  // random words in small maps
    localparam int unsigned DRAIN_PAUSE = 8;    // covers the two-stage pipeline

    // one expected result word
    typedef struct {
        logic            frontier;
        ofm_pkg::t_class cls;
        logic            last;
    } t_mark;

    // ------------------------------------------------------------------------
    // Frontier tracker: mirrors the block state and holds expected results.
    // ------------------------------------------------------------------------
    class frontier_tracker;
        int unsigned     width_reg;
        int unsigned     height_reg;
        ofm_pkg::t_class line_store[2][ofm_pkg::MAX_WIDTH_DEF];
        ofm_pkg::t_class win[3][3];     // [column][row], column 2 newest
        int unsigned     col;
        int unsigned     row;
        longint unsigned out_pos;
        t_mark           marks_due[$];
        int unsigned     errors;
        int unsigned     marks_seen;

        function new();
            width_reg  = ofm_pkg::WIDTH_RESET;
            height_reg = ofm_pkg::HEIGHT_RESET;
            errors     = 0;
            marks_seen = 0;
            foreach (line_store[i, j]) line_store[i][j] = ofm_pkg::CLS_FREE;
            restart();
        endfunction

        function void restart();
            foreach (win[i, j]) win[i][j] = ofm_pkg::CLS_FREE;
            col     = 0;
            row     = 0;
            out_pos = 0;
        endfunction

        function int unsigned map_w();
            if (width_reg == 0) return 1;
            if (width_reg > ofm_pkg::MAX_WIDTH_DEF) return ofm_pkg::MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned map_h();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned pending();
            return marks_due.size();
        endfunction

        function void write_reg(ofm_pkg::t_cfg_idx idx,
                                logic [ofm_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                ofm_pkg::REG_MAP_WIDTH:  width_reg = d[ofm_pkg::WIDTH_REG_W-1:0];
                ofm_pkg::REG_MAP_HEIGHT: height_reg = d;
                default: ;
            endcase
            restart();
        endfunction

        // Advances the window by one word; returns 0 for a dropped early drain.
        function bit take_word(ofm_pkg::t_op op, logic signed [ofm_pkg::CELL_W-1:0] v);
            int unsigned     w, h, orow, ocol, dx, dy;
            bit              past, frontier, last;
            ofm_pkg::t_class cls, top, mid, center;
            longint unsigned seen;
            t_mark           m;

            w    = map_w();
            h    = map_h();
            past = (row >= h);
            if (op == ofm_pkg::OP_DRAIN && !past) return 0;

            if (past || op == ofm_pkg::OP_DRAIN || v == 0) cls = ofm_pkg::CLS_FREE;
            else if (v < 0) cls = ofm_pkg::CLS_UNKNOWN;
            else cls = ofm_pkg::CLS_OCCUPIED;

            top = line_store[1][col];
            mid = line_store[0][col];
            line_store[1][col] = mid;
            line_store[0][col] = cls;
            win[0] = win[1];
            win[1] = win[2];
            win[2][0] = top;
            win[2][1] = mid;
            win[2][2] = cls;

            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end

            seen = longint'(row) * w + col;
            if (seen < out_pos + w + 1) return 1;

            orow     = int'(out_pos / w);
            ocol     = int'(out_pos % w);
            center   = win[1][1];
            frontier = 1'b0;
            if (center == ofm_pkg::CLS_FREE) begin
                for (dx = 0; dx < 3; dx++) begin
                    for (dy = 0; dy < 3; dy++) begin
                        // skip the center and anything off the map
                        if (dx == 1 && dy == 1) continue;
                        if (dx == 0 && ocol == 0) continue;
                        if (dx == 2 && ocol == w - 1) continue;
                        if (dy == 0 && orow == 0) continue;
                        if (dy == 2 && orow >= h - 1) continue;
                        if (win[dx][dy] == ofm_pkg::CLS_UNKNOWN) frontier = 1'b1;
                    end
                end
            end

            last       = (out_pos + 1 >= longint'(w) * h);
            m.frontier = frontier;
            m.cls      = center;
            m.last     = last;
            marks_due  = {marks_due, m};
            out_pos++;
            if (last) restart();
            return 1;
        endfunction

        task report(string msg);
            $display("[%0t] result %0d: %s", $realtime, marks_seen, msg);
            errors++;
        endtask

        task check_mark(logic f, logic [ofm_pkg::CLASS_W-1:0] c, logic l);
            t_mark m;
            if (marks_due.size() == 0) begin
                report("result with nothing expected");
            end else begin
                m = marks_due.pop_front();
                if (f !== m.frontier)
                    report($sformatf("is_frontier %b, want %b", f, m.frontier));
                if (c !== m.cls)
                    report($sformatf("cell_class %0d, want %0d", c, m.cls));
                if (l !== m.last)
                    report($sformatf("last_in_frame %b, want %b", l, m.last));
            end
            marks_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ofm_in_if  cell_bus ();
    ofm_out_if mark_bus ();
    ofm_cfg_if cfg_bus ();

    occupancy_frontier_mask dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_cell   (cell_bus),
        .o_result (mark_bus)
    );

    frontier_tracker tracker = new();

    bit          gaps_on   = 1'b1;  // random valid gaps on the cell side
    bit          stalls_on = 1'b1;  // random ready stalls on the result side
    int unsigned counted   = 0;     // words that moved the window

    // ------------------------------------------------------------------------
    // Result side: random ready bursts, and every accepted word checked.
    // Signals are read right after the edge, i.e. their pre-edge values.
    // ------------------------------------------------------------------------
    initial begin
        mark_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (stalls_on && $urandom_range(0, 4) == 0) begin
                mark_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            mark_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && mark_bus.valid && mark_bus.ready)
            tracker.check_mark(mark_bus.is_frontier, mark_bus.cell_class,
                               mark_bus.last_in_frame);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Free cells lead the mix so that frontiers show up; unknown and occupied values
    // use random magnitudes so every bit of the byte toggles.
    function automatic logic signed [ofm_pkg::CELL_W-1:0] random_cell();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4, 5, 6:    return {1'b1, 7'($urandom)};
            default:    return {1'b0, 7'($urandom_range(1, 127))};
        endcase
    endfunction

    // One word on the cell channel. Valid stays high after the handshake so
    // back-to-back words need no extra assignment; gaps lower it first.
    task automatic send_word(ofm_pkg::t_op op, logic signed [ofm_pkg::CELL_W-1:0] v);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            cell_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        cell_bus.valid      <= 1'b1;
        cell_bus.op         <= op;
        cell_bus.cell_value <= v;
        do @(posedge i_clk); while (!cell_bus.ready);
        if (tracker.take_word(op, v)) counted++;
    endtask

    // Waits for every expected word, then lets any dropped drain clear the
    // pipeline before the block is treated as idle.
    task automatic settle();
        cell_bus.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic put_reg(ofm_pkg::t_cfg_idx idx, logic [ofm_pkg::CFG_DATA_W-1:0] d);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= d;
        do @(posedge i_clk); while (!cfg_bus.ready);
        tracker.write_reg(idx, d);
    endtask

    // Both registers, in random order; either write restarts the map.
    task automatic set_map(logic [ofm_pkg::CFG_DATA_W-1:0] w_word,
                           logic [ofm_pkg::CFG_DATA_W-1:0] h_word);
        if ($urandom_range(0, 1) == 0) begin
            put_reg(ofm_pkg::REG_MAP_WIDTH, w_word);
            put_reg(ofm_pkg::REG_MAP_HEIGHT, h_word);
        end else begin
            put_reg(ofm_pkg::REG_MAP_HEIGHT, h_word);
            put_reg(ofm_pkg::REG_MAP_WIDTH, w_word);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // A run of w + 1 words that flushes the window, as drains or spare cells.
    task automatic flush_map(int unsigned w);
        int unsigned i;
        for (i = 0; i <= w; i++) begin
            if ($urandom_range(0, 2) == 0) send_word(ofm_pkg::OP_CELL, 8'($urandom));
            else send_word(ofm_pkg::OP_DRAIN, 8'($urandom));
        end
    endtask

    // Random small map: a few complete maps back to back, with early drains
    // as noise and now and then a map cut short by the next register write.
    task automatic run_map_phase();
        int unsigned w, h, maps, cells, cut, m, i;
        logic [ofm_pkg::CFG_DATA_W-1:0] w_word, h_word;

        w      = $urandom_range(1, 12);
        h      = $urandom_range(1, 6);
        w_word = {5'($urandom), 11'(w)};
        h_word = 16'(h);
        if ($urandom_range(0, 9) == 0) begin
            w      = 1;
            w_word = {5'($urandom), 11'd0};
        end
        if ($urandom_range(0, 9) == 0) begin
            h      = 1;
            h_word = '0;
        end
        set_map(w_word, h_word);

        maps = $urandom_range(1, 3);
        for (m = 0; m < maps; m++) begin
            cells = w * h;
            cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cells - 1) : cells;
            for (i = 0; i < cut; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_word(ofm_pkg::OP_DRAIN, 8'($urandom));
                send_word(ofm_pkg::OP_CELL, random_cell());
            end
            if (cut < cells) break;
            flush_map(w);
            // a drain right after completion hits a fresh map and is dropped
            if ($urandom_range(0, 3) == 0) send_word(ofm_pkg::OP_DRAIN, 8'($urandom));
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned i;

        i_rst_n             <= 1'b0;
        cell_bus.valid      <= 1'b0;
        cell_bus.op         <= ofm_pkg::OP_CELL;
        cell_bus.cell_value <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= ofm_pkg::REG_MAP_WIDTH;
        cfg_bus.data        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 map: byte extremes, all classes, a drain too early, then a flush
        // made of both drains and cells past the end
        set_map(16'd3, 16'd3);
        send_word(ofm_pkg::OP_CELL, 8'sd0);
        send_word(ofm_pkg::OP_CELL, -8'sd128);
        send_word(ofm_pkg::OP_CELL, 8'sd127);
        send_word(ofm_pkg::OP_DRAIN, 8'sh5A);
        send_word(ofm_pkg::OP_CELL, 8'sd0);
        send_word(ofm_pkg::OP_CELL, 8'sd0);
        send_word(ofm_pkg::OP_CELL, 8'sd1);
        send_word(ofm_pkg::OP_CELL, -8'sd1);
        send_word(ofm_pkg::OP_CELL, 8'sd0);
        send_word(ofm_pkg::OP_CELL, 8'sd0);
        send_word(ofm_pkg::OP_DRAIN, -8'sd1);
        send_word(ofm_pkg::OP_CELL, 8'sd127);
        send_word(ofm_pkg::OP_CELL, -8'sd1);
        send_word(ofm_pkg::OP_DRAIN, 8'sd0);
        settle();

        // zero width acts as one column; the bypass path of a one-wide map
        set_map(16'hF800, 16'd2);
        send_word(ofm_pkg::OP_CELL, 8'sd0);
        send_word(ofm_pkg::OP_CELL, -8'sd5);
        flush_map(1);
        settle();

        // zero height acts as one row; two single-cell maps back to back
        set_map(16'd1, 16'd0);
        send_word(ofm_pkg::OP_CELL, -8'sd1);
        flush_map(1);
        send_word(ofm_pkg::OP_CELL, 8'sd0);
        flush_map(1);
        settle();

        // tallest map, one column wide, left partial
        set_map(16'd1, 16'hFFFF);
        for (i = 0; i < 60; i++) send_word(ofm_pkg::OP_CELL, random_cell());
        settle();

        // random small maps; the tail runs without any idling
        counted = 0;
        while (counted < MAP_ITEMS) begin
            if (counted >= MAP_ITEMS * 4 / 5) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            run_map_phase();
        end

        settle();
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
